>>> sv/skb_pkg.sv
// Shared types, constants and saturation helpers for the vertex skinning blend core.
// Depends on nothing; used by every module of the block.
package skb_pkg;

    localparam int MAX_BONES    = 64;
    localparam int BONE_W       = 6;
    localparam int ENTRIES      = 12;
    localparam int ENTRY_W      = 4;
    localparam int INFLUENCES   = 4;
    localparam int WEIGHT_W     = 16;
    localparam int COORD_W      = 32;
    localparam int PROD_W       = 64;
    localparam int SUM_W        = 66;
    localparam int P_W          = 46;
    localparam int PW_W         = 63;
    localparam int ACC_W        = 65;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    typedef struct packed {
        logic                      en;
        logic [BONE_W-1:0]         bone;
        logic [ENTRY_W-1:0]        entry;
        logic signed [COORD_W-1:0] value;
    } wr_t;

    function automatic logic signed [P_W-1:0] sat_p(input logic signed [SUM_W-17:0] v);
        logic signed [SUM_W-17:0] hi;
        logic signed [SUM_W-17:0] lo;
        begin
            hi = (SUM_W-16)'((64'sd1 <<< (P_W-1)) - 64'sd1);
            lo = -hi - (SUM_W-16)'(1);
            if (v > hi)
                sat_p = hi[P_W-1:0];
            else if (v < lo)
                sat_p = lo[P_W-1:0];
            else
                sat_p = v[P_W-1:0];
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_out(input logic signed [ACC_W-16:0] v);
        begin
            if (v > (ACC_W-15)'(64'sh7FFF_FFFF))
                sat_out = 32'sh7FFF_FFFF;
            else if (v < -(ACC_W-15)'(64'sh8000_0000))
                sat_out = 32'sh8000_0000;
            else
                sat_out = v[COORD_W-1:0];
        end
    endfunction

endpackage

>>> sv/skb_lane.sv
// One influence lane: bone matrix copy, affine transform and weighting.
// Depends on skb_pkg.
module skb_lane
(
    input  logic                                 clk,
    input  logic                                 adv,
    input  skb_pkg::wr_t                         wr,
    input  logic                                 rd_en,
    input  logic [skb_pkg::BONE_W-1:0]           bone,
    input  logic signed [skb_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [skb_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [skb_pkg::COORD_W-1:0]   pos_z,
    input  logic [skb_pkg::WEIGHT_W-1:0]         weight,
    output logic signed [skb_pkg::PW_W-1:0]      pw_x,
    output logic signed [skb_pkg::PW_W-1:0]      pw_y,
    output logic signed [skb_pkg::PW_W-1:0]      pw_z
);

    logic signed [skb_pkg::COORD_W-1:0] mem [skb_pkg::MAX_BONES][skb_pkg::ENTRIES];
    logic signed [skb_pkg::COORD_W-1:0] row_reg [skb_pkg::ENTRIES];
    logic signed [skb_pkg::COORD_W-1:0] pos_reg [3];
    logic [skb_pkg::WEIGHT_W-1:0]       w1_reg, w2_reg, w3_reg;
    logic signed [skb_pkg::PROD_W-1:0]  prod_reg [3][3];
    logic signed [skb_pkg::COORD_W-1:0] t_reg [3];
    logic signed [skb_pkg::P_W-1:0]     p_reg [3];
    logic signed [skb_pkg::PW_W-1:0]    pw_reg [3];
    logic signed [skb_pkg::SUM_W-1:0]   sum [3];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.bone][wr.entry] <= wr.value;
        if (rd_en)
        begin
            row_reg    <= mem[bone];
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            w1_reg     <= weight;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            sum[c] = skb_pkg::SUM_W'(prod_reg[c][0]) + skb_pkg::SUM_W'(prod_reg[c][1])
                   + skb_pkg::SUM_W'(prod_reg[c][2])
                   + (skb_pkg::SUM_W'(t_reg[c]) <<< 16);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                    prod_reg[c][r] <= skb_pkg::PROD_W'(pos_reg[r]) *
                                      skb_pkg::PROD_W'(row_reg[r*3+c]);
                t_reg[c]  <= row_reg[9+c];
                p_reg[c]  <= skb_pkg::sat_p(sum[c][skb_pkg::SUM_W-1:16]);
                pw_reg[c] <= skb_pkg::PW_W'(p_reg[c]) *
                             skb_pkg::PW_W'($signed({1'b0, w3_reg}));
            end
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
        end
    end

    assign pw_x = pw_reg[0];
    assign pw_y = pw_reg[1];
    assign pw_z = pw_reg[2];

endmodule

>>> sv/skb_merge.sv
// Sum of the weighted lane results, flooring shift, saturation and output register.
// Depends on skb_pkg.
module skb_merge
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [skb_pkg::INFLUENCES-1:0]        active,
    input  logic signed [skb_pkg::PW_W-1:0]       pw [skb_pkg::INFLUENCES][3],
    output logic                                  out_valid,
    output logic [3*skb_pkg::COORD_W-1:0]         out_data
);

    logic signed [skb_pkg::ACC_W-1:0]   acc [3];
    logic signed [skb_pkg::COORD_W-1:0] res [3];
    logic                               valid_reg;
    logic [3*skb_pkg::COORD_W-1:0]      data_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = '0;
            for (int n = 0; n < skb_pkg::INFLUENCES; n++)
                if (active[n])
                    acc[c] = acc[c] + skb_pkg::ACC_W'(pw[n][c]);
            res[c] = skb_pkg::sat_out(acc[c][skb_pkg::ACC_W-1:15]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= {res[2], res[1], res[0]};
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/vertex_skinning_blend_core.sv
// Top level of the vertex skinning blend core: request unpacking, lanes and merge.
// Depends on skb_pkg, skb_lane and skb_merge.
//
// Linear blend skinning with four influences. A load request (tuser 0) with an entry
// index below 12 writes one Q16.16 matrix entry into every lane's bone store and
// returns nothing; a vertex request (tuser 1) returns one saturated Q16.16 position via
// the lane and merge registers. One request is taken every cycle while the output is
// free or taken; the whole pipeline holds while a result waits. Each of the four lanes
// keeps its own 64-bone store copy so all influences read their matrix in the same cycle.
module vertex_skinning_blend_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [231:0] s_tdata,  // matrix_bone, matrix_entry, entry_value, pos_x, pos_y,
                                   // pos_z, influence_bones, influence_weights, zero pad
    input  logic         s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata   // out_x, out_y, out_z
);

    logic                                adv;
    logic                                acc_in;
    logic                                vtx;
    skb_pkg::wr_t                        wr;
    logic [skb_pkg::INFLUENCES-1:0]      act;
    logic [3:0]                          v_reg;
    logic [skb_pkg::INFLUENCES-1:0]      mask_reg [4];
    logic signed [skb_pkg::PW_W-1:0]     pw [skb_pkg::INFLUENCES][3];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign acc_in   = s_tvalid && s_tready;
    assign vtx      = acc_in && (s_tuser == skb_pkg::CMD_VERTEX);

    always_comb
    begin
        wr.en    = acc_in && (s_tuser == skb_pkg::CMD_LOAD)
                   && (s_tdata[9:6] < 4'(skb_pkg::ENTRIES));
        wr.bone  = s_tdata[5:0];
        wr.entry = s_tdata[9:6];
        wr.value = s_tdata[41:10];
        act[0]   = s_tdata[177:162] != '0;
        for (int n = 1; n < skb_pkg::INFLUENCES; n++)
            act[n] = act[n-1] && (s_tdata[162 + 16*n +: 16] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], vtx};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mask_reg[0] <= act;
            mask_reg[1] <= mask_reg[0];
            mask_reg[2] <= mask_reg[1];
            mask_reg[3] <= mask_reg[2];
        end
    end

    for (genvar n = 0; n < skb_pkg::INFLUENCES; n++)
    begin : g_lane
        skb_lane u_lane
        (
            .clk    (clk),
            .adv    (adv),
            .wr     (wr),
            .rd_en  (vtx),
            .bone   (s_tdata[138 + 6*n +: 6]),
            .pos_x  (s_tdata[73:42]),
            .pos_y  (s_tdata[105:74]),
            .pos_z  (s_tdata[137:106]),
            .weight (s_tdata[162 + 16*n +: 16]),
            .pw_x   (pw[n][0]),
            .pw_y   (pw[n][1]),
            .pw_z   (pw[n][2])
        );
    end

    skb_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_reg[3]),
        .active    (mask_reg[3]),
        .pw        (pw),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && s_tuser == skb_pkg::CMD_LOAD) |=> !v_reg[0])
        else $error("load request entered the result pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && adv) |=> m_tvalid)
        else $error("pipeline result lost before output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved while output stalled");

endmodule
